/* rtl/core/rmq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // Width of every matrix element and quaternion component.
  localparam int DATA_WIDTH = 16;
  // Default number of fraction bits.
  localparam int FRAC_BITS = 14;
  // Number of minor components divided in parallel.
  localparam int NUM_LANES = 3;

  // Major axis codes.
  localparam logic [1:0] AXIS_TRACE = 2'd0;
  localparam logic [1:0] AXIS_X     = 2'd1;
  localparam logic [1:0] AXIS_Y     = 2'd2;
  localparam logic [1:0] AXIS_Z     = 2'd3;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] m00;
    logic signed [DATA_WIDTH-1:0] m01;
    logic signed [DATA_WIDTH-1:0] m02;
    logic signed [DATA_WIDTH-1:0] m10;
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m20;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;
  } matrix_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] qx;
    logic signed [DATA_WIDTH-1:0] qy;
    logic signed [DATA_WIDTH-1:0] qz;
    logic signed [DATA_WIDTH-1:0] qw;
    logic [1:0]                   major_axis;
    logic                         degenerate;
  } quat_t;

endpackage
`default_nettype wire

/* rtl/core/rmq_sqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one root bit resolved per register stage.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
  parameter int ROOT_W = 16,
  parameter int SB_W   = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [2*ROOT_W-1:0]   in_rad,
  input  wire logic [SB_W-1:0]       in_side,
  output logic                       out_valid,
  output logic [ROOT_W-1:0]          out_root,
  output logic [SB_W-1:0]            out_side
);

  localparam int RAD_W = 2 * ROOT_W;

  logic                v    [0:ROOT_W];
  logic [RAD_W-1:0]    rad  [0:ROOT_W];
  logic [ROOT_W-1:0]   rem  [0:ROOT_W];
  logic [ROOT_W-1:0]   root [0:ROOT_W];
  logic [SB_W-1:0]     side [0:ROOT_W];

  assign v[0]    = in_valid;
  assign rad[0]  = in_rad;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_side;

  for (genvar t = 0; t < ROOT_W; t++) begin : g_step
    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic              ge;
    logic [ROOT_W+1:0] rem_sub;

    always_comb begin
      // Bring down the next two radicand bits and try the next root bit.
      rem_sh  = {rem[t], rad[t][RAD_W-1 -: 2]};
      trial   = {root[t], 2'b01};
      ge      = (rem_sh >= trial);
      rem_sub = ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[t+1] <= 1'b0;
      end else if (en) begin
        v[t+1] <= v[t];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[t+1]  <= {rad[t][RAD_W-3:0], 2'b00};
        rem[t+1]  <= rem_sub[ROOT_W-1:0];
        root[t+1] <= {root[t][ROOT_W-2:0], ge};
        side[t+1] <= side[t];
      end
    end
  end

  assign out_valid = v[ROOT_W];
  assign out_root  = root[ROOT_W];
  assign out_side  = side[ROOT_W];

endmodule
`default_nettype wire

/* rtl/core/rmq_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider, several numerators over one shared divisor,
// one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rmq_div #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 17,
  parameter int SB_W  = 8
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         en,
  input  wire logic                                         in_valid,
  input  wire logic [rmq_pkg::NUM_LANES-1:0][NUM_W-1:0]     in_num,
  input  wire logic [DEN_W-1:0]                             in_den,
  input  wire logic [SB_W-1:0]                              in_side,
  output logic                                              out_valid,
  output logic [rmq_pkg::NUM_LANES-1:0][NUM_W-1:0]          out_quo,
  output logic [SB_W-1:0]                                   out_side
);

  localparam int NL = rmq_pkg::NUM_LANES;

  // The numerator register shifts left; quotient bits enter at the bottom.
  logic                          v    [0:NUM_W];
  logic [NL-1:0][NUM_W-1:0]      num  [0:NUM_W];
  logic [NL-1:0][DEN_W-1:0]      rem  [0:NUM_W];
  logic [DEN_W-1:0]              den  [0:NUM_W];
  logic [SB_W-1:0]               side [0:NUM_W];

  assign v[0]    = in_valid;
  assign num[0]  = in_num;
  assign rem[0]  = '0;
  assign den[0]  = in_den;
  assign side[0] = in_side;

  for (genvar t = 0; t < NUM_W; t++) begin : g_step
    logic [NL-1:0][NUM_W-1:0] num_next;
    logic [NL-1:0][DEN_W-1:0] rem_next;

    always_comb begin
      logic [DEN_W:0] sh;
      logic           ge;
      for (int l = 0; l < NL; l++) begin
        sh          = {rem[t][l], num[t][l][NUM_W-1]};
        ge          = (sh >= {1'b0, den[t]});
        rem_next[l] = ge ? DEN_W'(sh - {1'b0, den[t]}) : sh[DEN_W-1:0];
        num_next[l] = {num[t][l][NUM_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[t+1] <= 1'b0;
      end else if (en) begin
        v[t+1] <= v[t];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num[t+1]  <= num_next;
        rem[t+1]  <= rem_next;
        den[t+1]  <= den[t];
        side[t+1] <= side[t];
      end
    end
  end

  assign out_valid = v[NUM_W];
  assign out_quo   = num[NUM_W];
  assign out_side  = side[NUM_W];

endmodule
`default_nettype wire

/* rtl/core/rotation_matrix_to_quaternion.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix in signed fixed point to a quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_ready / in_data) carries one matrix per
//   transfer; the output channel (out_valid / out_ready / out_data) carries
//   one quaternion per transfer, with the chosen major axis and a flag for a
//   zero root. Results leave in the order the matrices came in.
//   From input transfer to out_valid a matrix passes the input register,
//   which loads at the transfer edge, then one setup stage (trace, axis
//   pick, radicand and numerators), one stage per root bit of the square
//   root pipeline, one stage per quotient bit of the three parallel
//   dividers and the output register.
//   Throughput is one matrix per cycle while out_ready stays high.
//   The whole pipeline advances together: when the output register holds a
//   result that is not taken, every stage freezes and in_ready drops, so
//   nothing is lost or repeated. Items in flight never block a new one.
//   Synchronous reset clears every valid bit; payload registers keep junk.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire rmq_pkg::matrix_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output rmq_pkg::quat_t       out_data
);

  localparam int DW = rmq_pkg::DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int NL = rmq_pkg::NUM_LANES;
  // Signed width for trace and radicand sums, including the added one.
  localparam int RW = (DW + 3 > FB + 2) ? DW + 3 : FB + 2;
  // Root width covers the radicand scaled up by the fraction bits.
  localparam int ROOT_W = (RW + FB) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  // Numerator magnitude width and scaled numerator (quotient) width.
  localparam int MAG_W = DW + 1;
  localparam int QUO_W = MAG_W + FB;
  localparam int DEN_W = ROOT_W + 1;
  localparam int CW    = (ROOT_W > DW) ? ROOT_W : DW;
  // Side bands: axis plus lane signs plus lane magnitudes, then axis, signs
  // and the root for the divider.
  localparam int SQ_SB  = 2 + NL + NL * MAG_W;
  localparam int DIV_SB = 2 + NL + ROOT_W;

  localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  // Whole-pipeline advance: the output register is empty or being drained.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Input register.
  logic             s1_valid;
  rmq_pkg::matrix_t s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= in_data;
    end
  end

  // Setup: trace, branch, major axis, radicand and the three numerators.
  logic [1:0]                 axis_c;
  logic [RAD_W-1:0]           rad_c;
  logic [NL-1:0]              sgn_c;
  logic [NL-1:0][MAG_W-1:0]   mag_c;

  always_comb begin
    logic signed [RW-1:0]   e00, e11, e22, tr, radd, one_v;
    logic signed [DW+1:0]   n [NL];
    logic signed [DW+1:0]   a01, a02, a10, a12, a20, a21;
    logic [RW-2:0]          r_u;
    e00   = RW'(s1.m00);
    e11   = RW'(s1.m11);
    e22   = RW'(s1.m22);
    one_v = RW'(1) << FB;
    a01   = (DW+2)'(s1.m01);
    a02   = (DW+2)'(s1.m02);
    a10   = (DW+2)'(s1.m10);
    a12   = (DW+2)'(s1.m12);
    a20   = (DW+2)'(s1.m20);
    a21   = (DW+2)'(s1.m21);
    tr    = e00 + e11 + e22;
    if (tr > 0) begin
      axis_c = rmq_pkg::AXIS_TRACE;
      radd   = tr + one_v;
      n[0]   = a12 - a21;
      n[1]   = a20 - a02;
      n[2]   = a01 - a10;
    end else if ((e22 > e11 && e11 > e00) || (e22 > e00 && !(e11 > e00))) begin
      // Ties keep the lower axis: z wins only when strictly above the pick.
      axis_c = rmq_pkg::AXIS_Z;
      radd   = e22 - (e00 + e11) + one_v;
      n[0]   = a01 - a10;
      n[1]   = a20 + a02;
      n[2]   = a21 + a12;
    end else if (e11 > e00) begin
      axis_c = rmq_pkg::AXIS_Y;
      radd   = e11 - (e22 + e00) + one_v;
      n[0]   = a20 - a02;
      n[1]   = a12 + a21;
      n[2]   = a10 + a01;
    end else begin
      axis_c = rmq_pkg::AXIS_X;
      radd   = e00 - (e11 + e22) + one_v;
      n[0]   = a12 - a21;
      n[1]   = a01 + a10;
      n[2]   = a02 + a20;
    end
    // A negative radicand is clamped to zero.
    r_u   = radd[RW-1] ? '0 : radd[RW-2:0];
    rad_c = RAD_W'(r_u) << FB;
    for (int l = 0; l < NL; l++) begin
      sgn_c[l] = n[l][DW+1];
      mag_c[l] = n[l][DW+1] ? MAG_W'(-n[l]) : MAG_W'(n[l]);
    end
  end

  logic              s2_valid;
  logic [RAD_W-1:0]  s2_rad;
  logic [SQ_SB-1:0]  s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_rad  <= rad_c;
      s2_side <= {axis_c, sgn_c, mag_c};
    end
  end

  // Square root pipeline.
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  logic [SQ_SB-1:0]  sq_side;

  rmq_sqrt #(
    .ROOT_W (ROOT_W),
    .SB_W   (SQ_SB)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s2_valid),
    .in_rad    (s2_rad),
    .in_side   (s2_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Divider pipeline: each minor part is (|D| << FB) / (2 * root).
  logic [1:0]                sq_axis;
  logic [NL-1:0]             sq_sgn;
  logic [NL-1:0][MAG_W-1:0]  sq_mag;
  logic [NL-1:0][QUO_W-1:0]  dv_num;

  assign {sq_axis, sq_sgn, sq_mag} = sq_side;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      dv_num[l] = QUO_W'(sq_mag[l]) << FB;
    end
  end

  logic                      dv_valid;
  logic [NL-1:0][QUO_W-1:0]  dv_quo;
  logic [DIV_SB-1:0]         dv_side;

  rmq_div #(
    .NUM_W (QUO_W),
    .DEN_W (DEN_W),
    .SB_W  (DIV_SB)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .in_num    (dv_num),
    .in_den    ({sq_root, 1'b0}),
    .in_side   ({sq_axis, sq_sgn, sq_root}),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // Saturate a sign and magnitude quotient into the signed output range.
  function automatic logic [DW-1:0] sat_minor(input logic neg, input logic [QUO_W-1:0] q);
    logic big;
    big = |q[QUO_W-1:DW-1];
    if (neg) begin
      sat_minor = big ? SMIN : DW'(-q[DW-1:0]);
    end else begin
      sat_minor = big ? SMAX : q[DW-1:0];
    end
  endfunction

  logic [1:0]        f_axis;
  logic [NL-1:0]     f_sgn;
  logic [ROOT_W-1:0] f_root;
  rmq_pkg::quat_t    res_c;

  assign {f_axis, f_sgn, f_root} = dv_side;

  always_comb begin
    logic [DW-1:0]     maj;
    logic [DW-1:0]     p [NL];
    logic [ROOT_W-1:0] half;
    logic              zero;
    zero = (f_root == '0);
    half = f_root >> 1;
    maj  = (CW'(half) > CW'(SMAX)) ? SMAX : DW'(half);
    for (int l = 0; l < NL; l++) begin
      p[l] = zero ? '0 : sat_minor(f_sgn[l], dv_quo[l]);
    end
    res_c.major_axis = f_axis;
    res_c.degenerate = zero && (f_axis != rmq_pkg::AXIS_TRACE);
    case (f_axis)
      rmq_pkg::AXIS_TRACE: begin
        res_c.qx = p[0];
        res_c.qy = p[1];
        res_c.qz = p[2];
        res_c.qw = maj;
      end
      rmq_pkg::AXIS_X: begin
        res_c.qx = maj;
        res_c.qw = p[0];
        res_c.qy = p[1];
        res_c.qz = p[2];
      end
      rmq_pkg::AXIS_Y: begin
        res_c.qy = maj;
        res_c.qw = p[0];
        res_c.qz = p[1];
        res_c.qx = p[2];
      end
      default: begin
        res_c.qz = maj;
        res_c.qw = p[0];
        res_c.qx = p[1];
        res_c.qy = p[2];
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res_c;
    end
  end

endmodule
`default_nettype wire
